@@ rtl/f12csw_pkg.sv @@
package f12csw_pkg;

	typedef enum logic [1:0] {
		OP_LOAD        = 2'd0,
		OP_OPEN_CHAIN  = 2'd1,
		OP_OPEN_CONTIG = 2'd2,
		OP_ADVANCE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_REPORT
	} state_t;

	// table lookup request toward the table store
	typedef struct packed {
		logic        en;
		logic [11:0] cluster;
	} lookup_req_t;

	// table byte write toward the table store
	typedef struct packed {
		logic        en;
		logic [12:0] addr;
		logic [7:0]  data;
	} table_wr_t;

	localparam logic [7:0]  MAX_SPC      = 8'd128;
	localparam logic [7:0]  SPC_RESET    = 8'd1;
	localparam logic [19:0] FIRST_DATA_CLUSTER = 20'd2;
	localparam logic [11:0] ENTRY_MASK   = 12'hFFF;

	// configuration register byte addresses
	localparam logic [2:0] REG_SPC        = 3'd0;
	localparam logic [2:0] REG_DATA_START = 3'd4;

endpackage

@@ rtl/f12csw_fat_table.sv @@
module f12csw_fat_table #(
	parameter int TABLE_BYTES = 8192
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  f12csw_pkg::table_wr_t    wr,
	input  f12csw_pkg::lookup_req_t  req,
	output logic [11:0]              entry
);
	import f12csw_pkg::*;

	localparam int BANK_DEPTH = TABLE_BYTES / 2;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam logic [13:0] TABLE_LIMIT = 14'(TABLE_BYTES);

	// even and odd byte banks, so both bytes of a word come in one read
	logic [7:0] even_mem [BANK_DEPTH];
	logic [7:0] odd_mem  [BANK_DEPTH];

	logic [12:0] at_lo;
	logic [12:0] at_hi;
	logic        lo_ok;
	logic        hi_ok;
	logic        wr_ok;

	logic [7:0]  even_rd_s1;
	logic [7:0]  odd_rd_s1;
	logic        lo_odd_s1;
	logic        lo_ok_s1;
	logic        hi_ok_s1;
	logic        clus_odd_s1;

	logic [7:0]  lo_byte;
	logic [7:0]  hi_byte;
	logic [15:0] word;

	// byte offset of the entry is cluster * 3 / 2
	assign at_lo = {1'b0, req.cluster} + {2'b00, req.cluster[11:1]};
	assign at_hi = at_lo + 13'd1;
	assign lo_ok = {1'b0, at_lo} < TABLE_LIMIT;
	assign hi_ok = {1'b0, at_hi} < TABLE_LIMIT;
	assign wr_ok = wr.en && ({1'b0, wr.addr} < TABLE_LIMIT);

	always_ff @(posedge clk) begin
		if (wr_ok && !wr.addr[0]) begin
			even_mem[wr.addr[BANK_AW:1]] <= wr.data;
		end
		if (wr_ok && wr.addr[0]) begin
			odd_mem[wr.addr[BANK_AW:1]] <= wr.data;
		end
		if (req.en) begin
			// the even byte of the pair is at_hi when at_lo is odd
			even_rd_s1 <= even_mem[at_hi[BANK_AW:1]];
			odd_rd_s1  <= odd_mem[at_lo[BANK_AW:1]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_odd_s1   <= 1'b0;
			lo_ok_s1    <= 1'b0;
			hi_ok_s1    <= 1'b0;
			clus_odd_s1 <= 1'b0;
		end else if (req.en) begin
			lo_odd_s1   <= at_lo[0];
			lo_ok_s1    <= lo_ok;
			hi_ok_s1    <= hi_ok;
			clus_odd_s1 <= req.cluster[0];
		end
	end

	// bytes beyond the store read as zero
	always_comb begin
		lo_byte = lo_odd_s1 ? odd_rd_s1 : even_rd_s1;
		hi_byte = lo_odd_s1 ? even_rd_s1 : odd_rd_s1;
		if (!lo_ok_s1) begin
			lo_byte = 8'd0;
		end
		if (!hi_ok_s1) begin
			hi_byte = 8'd0;
		end
		word  = {hi_byte, lo_byte};
		entry = clus_odd_s1 ? word[15:4] : (word[11:0] & ENTRY_MASK);
	end

endmodule

@@ rtl/fat12_chain_sector_walker.sv @@
// FAT12 chain sector walker. Load the FAT into the table store with load
// beats, then open a chain at a cluster or a contiguous region at a sector and
// step through it with advance beats; each open or advance gives one result
// (logical sector, cluster, sector in cluster), a load gives none. A beat is
// taken at a clock edge with start high and busy low; a load leaves the block idle.
// Every open or advance passes the accept cycle, which updates the walk state, then
// the report state, which forms the sector number (one 20x8 multiply and add) into
// the output registers; an advance that leaves a cluster passes the lookup state in
// between, for the synchronous read of the table store. The result is shown for
// exactly one cycle with done high, the first cycle with busy low again; the
// receiver cannot stall it, so it must sample on done. The next beat may be
// accepted in that same cycle. End of chain is not detected: the raw table entry
// becomes the cluster. Table bytes must be loaded before they are walked through;
// bytes past the store read as zero and loads past it are dropped. Configuration
// writes are meant for idle periods only.
module fat12_chain_sector_walker #(
	parameter int TABLE_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [12:0] table_address,
	input  logic [7:0]  table_byte,
	input  logic [11:0] start_cluster,
	input  logic [19:0] start_sector,
	// result side
	output logic        done,
	output logic [19:0] sector_lba,
	output logic [11:0] cluster,
	output logic [6:0]  sector_in_cluster,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import f12csw_pkg::*;

	state_t state_q;
	state_t state_d;

	// configuration registers
	logic [7:0]  spc_q;
	logic [15:0] data_start_q;

	// walk state
	logic [11:0] cluster_q;
	logic [6:0]  offset_q;
	logic [19:0] contig_q;
	logic        contig_mode_q;

	// result registers
	logic        done_q;
	logic [19:0] lba_q;
	logic [11:0] res_cluster_q;
	logic [6:0]  res_offset_q;

	logic        accept;
	logic        cfg_wr;
	logic [7:0]  eff_spc;
	logic [7:0]  next_offset;
	logic        crosses;
	logic [19:0] clus_rel;
	logic [27:0] prod;
	logic [19:0] chain_lba;

	lookup_req_t req;
	table_wr_t   tbl_wr;
	logic [11:0] entry;

	assign accept = start && (state_q == ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;

	// counts above 128 act as 128
	assign eff_spc     = (spc_q > MAX_SPC) ? MAX_SPC : spc_q;
	assign next_offset = {1'b0, offset_q} + 8'd1;
	assign crosses     = next_offset >= eff_spc;

	// data_start + (cluster - 2) * spc + offset, all modulo 2^20
	assign clus_rel  = {8'd0, cluster_q} - FIRST_DATA_CLUSTER;
	assign prod      = 28'(clus_rel) * 28'(eff_spc);
	assign chain_lba = {4'd0, data_start_q} + prod[19:0] + {13'd0, offset_q};

	assign tbl_wr.en   = accept && (op_t'(operation) == OP_LOAD);
	assign tbl_wr.addr = table_address;
	assign tbl_wr.data = table_byte;

	f12csw_fat_table #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (tbl_wr),
		.req   (req),
		.entry (entry)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'd0, data_start_q} : {24'd0, spc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q        <= SPC_RESET;
			data_start_q <= 16'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DATA_START[2]) begin
				data_start_q <= pwdata[15:0];
			end else begin
				spc_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, busy and the table read request
	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		req.en      = 1'b0;
		req.cluster = cluster_q;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					unique case (op_t'(operation))
						OP_LOAD: state_d = ST_IDLE;
						OP_OPEN_CHAIN, OP_OPEN_CONTIG: state_d = ST_REPORT;
						OP_ADVANCE: begin
							if (!contig_mode_q && crosses) begin
								// leaving the cluster: fetch its table entry
								req.en  = 1'b1;
								state_d = ST_LOOKUP;
							end else begin
								state_d = ST_REPORT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOOKUP: state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// walk state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_q     <= 12'd0;
			offset_q      <= 7'd0;
			contig_q      <= 20'd0;
			contig_mode_q <= 1'b0;
		end else if (accept) begin
			case (op_t'(operation))
				OP_OPEN_CHAIN: begin
					cluster_q     <= start_cluster;
					offset_q      <= 7'd0;
					contig_mode_q <= 1'b0;
				end
				OP_OPEN_CONTIG: begin
					contig_q      <= start_sector;
					contig_mode_q <= 1'b1;
				end
				OP_ADVANCE: begin
					if (contig_mode_q) begin
						contig_q <= contig_q + 20'd1;
					end else if (crosses) begin
						offset_q <= 7'd0;
					end else begin
						offset_q <= next_offset[6:0];
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_LOOKUP) begin
			// entry read came back: follow the chain
			cluster_q <= entry;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_REPORT);
		end
	end

	// result payload, formed in the report cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_REPORT) begin
			if (contig_mode_q) begin
				lba_q         <= contig_q;
				res_cluster_q <= 12'd0;
				res_offset_q  <= 7'd0;
			end else begin
				lba_q         <= chain_lba;
				res_cluster_q <= cluster_q;
				res_offset_q  <= offset_q;
			end
		end
	end

	assign done              = done_q;
	assign sector_lba        = lba_q;
	assign cluster           = res_cluster_q;
	assign sector_in_cluster = res_offset_q;

endmodule

@@ tb/fat12_chain_sector_walker_tb.sv @@
`timescale 1ns / 100ps

module fat12_chain_sector_walker_tb;

	import f12csw_pkg::*;

	// store size of the block and the watchdog limit in cycles without a handshake
	localparam int FAT_BYTES = 8192;
	localparam int STALL_LIMIT = 2000;

	// one command beat, every field as the block sees it
	typedef struct packed {
		op_t         op;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [11:0] clus;
		logic [19:0] sec;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [19:0] lba;
		logic [11:0] clus;
		logic [6:0]  sic;
	} sector_t;

	// directed row: a command and, where obvious, the result it must give
	typedef struct {
		cmd_t    cmd;
		bit      typed;
		sector_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [12:0] table_address;
	logic [7:0]  table_byte;
	logic [11:0] start_cluster;
	logic [19:0] start_sector;
	logic        done;
	logic [19:0] sector_lba;
	logic [11:0] cluster;
	logic [6:0]  sector_in_cluster;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fat12_chain_sector_walker u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.table_address     (table_address),
		.table_byte        (table_byte),
		.start_cluster     (start_cluster),
		.start_sector      (start_sector),
		.done              (done),
		.sector_lba        (sector_lba),
		.cluster           (cluster),
		.sector_in_cluster (sector_in_cluster),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	// walker state as this bench tracks it
	logic [7:0]  spc_m;
	logic [15:0] dstart_m;
	logic [11:0] cur_clus;
	logic [6:0]  cur_off;
	logic [19:0] run_sector;
	logic        run_mode;      // high while walking a contiguous region
	logic [7:0]  fat_img [0:FAT_BYTES-1];
	bit          fat_valid [0:FAT_BYTES-1];

	// results still owed by the block, oldest first
	sector_t pending_sectors [$];
	sector_t due;
	row_t    rows [$];

	int errors;
	int n_beats;
	int n_results;
	int n_loads;
	int n_hops;
	int n_cfg;
	int idle_pct;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------------

	// cluster size as the block uses it: anything above 128 acts as 128
	function automatic logic [7:0] eff_spc();
		return (spc_m > MAX_SPC) ? MAX_SPC : spc_m;
	endfunction

	// byte offset of the packed 12-bit entry of a cluster
	function automatic logic [12:0] entry_at(logic [11:0] c);
		logic [13:0] t;
		t = (14'(c) * 14'd3) >> 1;
		return t[12:0];
	endfunction

	// next advance leaves the cluster and reads the table
	function automatic logic hop_pending();
		return !run_mode && (8'(cur_off) + 8'd1 >= eff_spc());
	endfunction

	// sector the walk points at now; cluster below two wraps through the 2^20 space
	function automatic sector_t current_sector();
		sector_t     r;
		logic [31:0] t;
		if (run_mode) begin
			r.lba = run_sector;
			r.clus = '0;
			r.sic = '0;
		end else begin
			t = 32'(dstart_m) + (32'(cur_clus) - 32'd2) * 32'(eff_spc()) + 32'(cur_off);
			r.lba = t[19:0];
			r.clus = cur_clus;
			r.sic = cur_off;
		end
		return r;
	endfunction

	task automatic walk_step(input cmd_t c, output bit has_res, output sector_t r);
		logic [12:0] at;
		logic [15:0] word;
		has_res = 1'b1;
		case (c.op)
			OP_LOAD: begin
				has_res = 1'b0;
				n_loads++;
				// loads past the store are dropped
				if (int'(c.addr) < FAT_BYTES) begin
					fat_img[c.addr] = c.data;
					fat_valid[c.addr] = 1'b1;
				end
			end
			OP_OPEN_CHAIN: begin
				cur_clus = c.clus;
				cur_off = '0;
				run_mode = 1'b0;
			end
			OP_OPEN_CONTIG: begin
				run_sector = c.sec;
				run_mode = 1'b1;
			end
			default: begin
				if (run_mode) begin
					run_sector = run_sector + 20'd1;
				end else if (hop_pending()) begin
					// follow the table; the raw entry is kept even at end of chain
					at = entry_at(cur_clus);
					word = {fat_img[at + 13'd1], fat_img[at]};
					cur_clus = cur_clus[0] ? word[15:4] : word[11:0];
					cur_off = '0;
					n_hops++;
				end else begin
					cur_off = cur_off + 7'd1;
				end
			end
		endcase
		r = current_sector();
	endtask

	// ---------------------------------------------------------------------------
	// result side: the block cannot be stalled, so every done beat is checked
	// ---------------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_sectors.size() == 0) begin
				$error("result beat with nothing expected: sector_lba %h cluster %h",
					sector_lba, cluster);
				errors++;
			end else begin
				due = pending_sectors.pop_front();
				n_results++;
				if (sector_lba !== due.lba) begin
					$error("sector_lba mismatch: expected %h, got %h", due.lba, sector_lba);
					errors++;
				end
				if (cluster !== due.clus) begin
					$error("cluster mismatch: expected %h, got %h", due.clus, cluster);
					errors++;
				end
				if (sector_in_cluster !== due.sic) begin
					$error("sector_in_cluster mismatch: expected %h, got %h",
						due.sic, sector_in_cluster);
					errors++;
				end
			end
		end
	end

	// watchdog: any command, result or register beat resets the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------------
	// command side
	// ---------------------------------------------------------------------------

	// present one beat, hold it until taken, then predict; start stays high on
	// return so a back-to-back beat needs only one assignment in that step
	task automatic send_beat(input cmd_t c, input bit typed, input sector_t want);
		bit      has_res;
		sector_t got;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= c.op;
		table_address <= c.addr;
		table_byte <= c.data;
		start_cluster <= c.clus;
		start_sector <= c.sec;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		walk_step(c, has_res, got);
		n_beats++;
		if (has_res)
			pending_sectors.push_back(typed ? want : got);
	endtask

	// unused fields carry random junk the block must ignore
	function automatic cmd_t rand_cmd(op_t op);
		cmd_t c;
		c.op = op;
		c.addr = 13'($urandom);
		c.data = 8'($urandom);
		c.clus = 12'($urandom);
		c.sec = 20'($urandom);
		return c;
	endfunction

	task automatic send_rand(input cmd_t c);
		send_beat(c, 1'b0, '0);
	endtask

	task automatic load_byte(input logic [12:0] a, input logic [7:0] d);
		cmd_t c;
		c = rand_cmd(OP_LOAD);
		c.addr = a;
		c.data = d;
		send_rand(c);
	endtask

	// never let a hop read a table byte that was not loaded
	task automatic advance();
		logic [12:0] at;
		if (hop_pending()) begin
			at = entry_at(cur_clus);
			if (!fat_valid[at])
				load_byte(at, 8'($urandom));
			if (!fat_valid[at + 13'd1])
				load_byte(at + 13'd1, 8'($urandom));
		end
		send_rand(rand_cmd(OP_ADVANCE));
	endtask

	// write a 12-bit entry, keeping the neighbor's nibble in the shared byte
	task automatic set_link(input logic [11:0] from, input logic [11:0] to);
		logic [12:0] at;
		logic [7:0]  lo;
		logic [7:0]  hi;
		at = entry_at(from);
		lo = fat_valid[at] ? fat_img[at] : 8'($urandom);
		hi = fat_valid[at + 13'd1] ? fat_img[at + 13'd1] : 8'($urandom);
		if (from[0]) begin
			lo = {to[3:0], lo[3:0]};
			hi = to[11:4];
		end else begin
			lo = to[7:0];
			hi = {hi[7:4], to[11:8]};
		end
		load_byte(at, lo);
		load_byte(at + 13'd1, hi);
	endtask

	// build a short cluster chain in the table, open it and walk through it
	task automatic walk_file();
		logic [11:0] links [4];
		int          n;
		int          kmax;
		cmd_t        c;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			links[i] = ($urandom_range(9) == 0) ? 12'($urandom_range(0, 1))
				: 12'($urandom_range(2, 4095));
		for (int i = 0; i < n - 1; i++)
			set_link(links[i], links[i + 1]);
		// end of chain marker, or a random raw entry
		set_link(links[n - 1], $urandom_range(1) ? ENTRY_MASK : 12'($urandom));
		c = rand_cmd(OP_OPEN_CHAIN);
		c.clus = links[0];
		send_rand(c);
		kmax = (eff_spc() == 0) ? n + 2 : int'(eff_spc()) * n + 2;
		if (kmax > 260)
			kmax = 260;
		repeat ($urandom_range(0, kmax))
			advance();
	endtask

	// contiguous region, now and then close to the top of the sector space
	task automatic walk_region();
		cmd_t c;
		c = rand_cmd(OP_OPEN_CONTIG);
		if ($urandom_range(3) == 0)
			c.sec = 20'hFFFFF - 20'($urandom_range(0, 3));
		send_rand(c);
		repeat ($urandom_range(0, 6))
			advance();
	endtask

	// lone beats of any kind
	task automatic stray_beat();
		case ($urandom_range(3))
			0: send_rand(rand_cmd(OP_LOAD));
			1: advance();
			2: send_rand(rand_cmd(OP_OPEN_CHAIN));
			default: send_rand(rand_cmd(OP_OPEN_CONTIG));
		endcase
	endtask

	// ---------------------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------------------

	// let every owed result arrive, then give a trailing load time to finish
	task automatic settle();
		start <= 1'b0;
		while (pending_sectors.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write a register, then read it back
	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		logic [31:0] mask;
		mask = (a == REG_SPC) ? 32'h0000_00FF : 32'h0000_FFFF;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (a == REG_SPC)
			spc_m = d[7:0];
		else
			dstart_m = d[15:0];
		n_cfg++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & mask) !== (d & mask)) begin
			$error("prdata mismatch at %0d: expected %h, got %h", a, d & mask, prdata & mask);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] spc, input logic [15:0] ds, input int pct,
		input int budget);
		int base;
		int pick;
		settle();
		reg_write(REG_SPC, 32'(spc));
		reg_write(REG_DATA_START, 32'(ds));
		idle_pct = pct;
		base = n_beats;
		while (n_beats - base < budget) begin
			pick = $urandom_range(99);
			if (pick < 65)
				walk_file();
			else if (pick < 85)
				walk_region();
			else
				stray_beat();
		end
	endtask

	task automatic add_row(input op_t op, input logic [12:0] a, input logic [7:0] d,
		input logic [11:0] cl, input logic [19:0] s, input bit typed,
		input logic [19:0] lba, input logic [11:0] rc, input logic [6:0] sic);
		row_t r;
		r.cmd = '{op: op, addr: a, data: d, clus: cl, sec: s};
		r.typed = typed;
		r.want = '{lba: lba, clus: rc, sic: sic};
		rows.push_back(r);
	endtask

	// ---------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_LOAD;
		table_address <= '0;
		table_byte <= '0;
		start_cluster <= '0;
		start_sector <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= REG_SPC;
		pwdata <= '0;
		errors = 0;
		n_beats = 0;
		n_results = 0;
		n_loads = 0;
		n_hops = 0;
		n_cfg = 0;
		idle_pct = 0;
		spc_m = SPC_RESET;
		dstart_m = '0;
		cur_clus = '0;
		cur_off = '0;
		run_sector = '0;
		run_mode = 1'b0;
		for (int i = 0; i < FAT_BYTES; i++) begin
			fat_img[i] = '0;
			fat_valid[i] = 1'b0;
		end

		// directed part, reset configuration: one sector per cluster, data at 0
		// entry of cluster 0 is 0x003, so the first advance lands on cluster 3
		add_row(OP_LOAD, 13'd0, 8'h03, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_LOAD, 13'd1, 8'h40, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b1, 20'd1, 12'h003, 7'd0);
		// odd cluster 3 takes the upper 12 bits: end of chain marker kept raw
		add_row(OP_LOAD, 13'd4, 8'hF0, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_LOAD, 13'd5, 8'hFF, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b1, 20'h00FFD, 12'hFFF, 7'd0);
		// highest entry in the table points to cluster 1, below two wraps
		add_row(OP_LOAD, 13'd6142, 8'h10, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_LOAD, 13'd6143, 8'h00, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b1, 20'hFFFFF, 12'h001, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'h000, '0, 1'b1, 20'hFFFFE, 12'h000, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'hFFF, '0, 1'b1, 20'h00FFD, 12'hFFF, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'hAAA, '0, 1'b1, 20'h00AA8, 12'hAAA, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'h555, '0, 1'b1, 20'h00553, 12'h555, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'h002, '0, 1'b1, 20'h00000, 12'h002, 7'd0);
		add_row(OP_OPEN_CHAIN, '0, '0, 12'h003, '0, 1'b0, '0, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b0, '0, '0, '0);
		// contiguous region: wraps past the top of the sector space
		add_row(OP_OPEN_CONTIG, '0, '0, '0, 20'hFFFFF, 1'b1, 20'hFFFFF, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b1, 20'h00000, '0, '0);
		add_row(OP_OPEN_CONTIG, '0, '0, '0, 20'hAAAAA, 1'b1, 20'hAAAAA, '0, '0);
		add_row(OP_ADVANCE, '0, '0, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_OPEN_CONTIG, '0, '0, '0, 20'h55555, 1'b1, 20'h55555, '0, '0);
		// loads at the top of the address range and across the upper half
		add_row(OP_LOAD, 13'd8191, 8'hFF, '0, '0, 1'b0, '0, '0, '0);
		add_row(OP_LOAD, 13'd4096, 8'h5A, '0, '0, 1'b0, '0, '0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_beat(rows[i].cmd, rows[i].typed, rows[i].want);

		// random part: register extremes, zero and oversized clusters, idling mixes
		run_phase(8'd4, 16'd100, 0, 140);
		run_phase(8'd0, 16'hFFFF, 58, 130);
		run_phase(MAX_SPC, 16'd0, 0, 110);
		run_phase(8'd255, 16'($urandom), 20, 90);
		run_phase(8'd2, 16'($urandom), 58, 130);
		run_phase(8'($urandom_range(1, 8)), 16'($urandom), 20, 130);
		run_phase(8'd1, 16'hFFFF, 0, 120);

		// drain, then a few cycles for anything unexpected to show up
		settle();
		repeat (8) @(posedge clk);

		$display("run: %0d command beats, %0d results checked, %0d table loads, %0d cluster hops",
			n_beats, n_results, n_loads, n_hops);
		$display("run: %0d register writes, cluster sizes 0 to 255, sender idle 0/20/58 pct",
			n_cfg);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
